### rtl/rid_pkg.sv
package rid_pkg;

    localparam logic [14:0] BASE_RESET = 15'd101;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_EXHAUSTED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_READ
    } back_state_t;

    // classification of a queued request, decided at the front
    typedef struct packed {
        logic is_free;
        logic in_range;
    } req_class_t;

endpackage

### rtl/rid_ram.sv
module rid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rid_front.sv
module rid_front #(
    parameter int MAX_IDS = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       cmd,
    input  logic [15:0]                free_id,
    input  logic [14:0]                base_id,
    input  logic                       clearing,
    input  logic                       pop,
    output logic                       q_valid,
    output rid_pkg::req_class_t        q_cls,
    output logic [$clog2(MAX_IDS)-1:0] q_slot
);

    localparam int SW = $clog2(MAX_IDS);

    rid_pkg::req_class_t   cls_reg [2];
    logic [SW-1:0]         slot_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;

    logic [16:0]           diff;
    rid_pkg::req_class_t   cls_in;
    logic                  push;

    // slot = free_id - base_id; out of range when negative or past the pool
    assign diff            = {1'b0, free_id} - {2'b00, base_id};
    assign cls_in.is_free  = (cmd == rid_pkg::CMD_FREE);
    assign cls_in.in_range = !diff[16] && (diff < 17'(MAX_IDS));

    assign busy    = (count_reg == 2'd2) || clearing;
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_cls   = cls_reg[rd_ptr_reg];
    assign q_slot  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cls_reg[wr_ptr_reg]  <= cls_in;
            slot_reg[wr_ptr_reg] <= diff[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/rid_back.sv
module rid_back #(
    parameter int MAX_IDS = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [14:0]                base_id,
    input  logic                       q_valid,
    input  rid_pkg::req_class_t        q_cls,
    input  logic [$clog2(MAX_IDS)-1:0] q_slot,
    output logic                       pop,
    output logic                       clearing,
    output logic                       done,
    output logic [15:0]                granted_id,
    output rid_pkg::status_t           status
);

    localparam int SW = $clog2(MAX_IDS);
    localparam int CW = $clog2(MAX_IDS + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_IDS - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_IDS);

    rid_pkg::back_state_t state_reg;
    rid_pkg::back_state_t state_next;

    logic [CW-1:0]        fill_reg,    fill_next;
    logic [CW-1:0]        fresh_reg,   fresh_next;
    logic [SW-1:0]        rd_ptr_reg,  rd_ptr_next;
    logic [SW-1:0]        wr_ptr_reg,  wr_ptr_next;
    logic [SW-1:0]        clr_idx_reg;
    logic                 hold_free_reg;
    logic [SW-1:0]        hold_slot_reg;
    logic                 done_reg,    done_next;
    logic [15:0]          granted_reg, granted_next;
    rid_pkg::status_t     status_reg,  status_next;

    logic                 map_we;
    logic [SW-1:0]        map_waddr;
    logic                 map_wdata;
    logic                 map_rdata;
    logic                 fifo_we;
    logic [SW-1:0]        fifo_rdata;

    rid_ram #(.WIDTH(1), .DEPTH(MAX_IDS)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (q_slot),
        .rdata (map_rdata)
    );

    rid_ram #(.WIDTH(SW), .DEPTH(MAX_IDS)) u_fifo (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (wr_ptr_reg),
        .wdata (hold_slot_reg),
        .raddr (rd_ptr_reg),
        .rdata (fifo_rdata)
    );

    function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + SW'(1);
    endfunction

    function automatic logic [15:0] id_of(input logic [14:0] base, input logic [SW-1:0] s);
        return 16'(base) + 16'(s);
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rid_pkg::BS_CLEAR:
            begin
                if (clr_idx_reg == LAST_SLOT)
                begin
                    state_next = rid_pkg::BS_IDLE;
                end
            end
            rid_pkg::BS_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cls.is_free ? q_cls.in_range : (fill_reg != '0))
                    begin
                        state_next = rid_pkg::BS_READ;
                    end
                end
            end
            rid_pkg::BS_READ:
            begin
                state_next = rid_pkg::BS_IDLE;
            end
            default:
            begin
                state_next = rid_pkg::BS_CLEAR;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        pop          = 1'b0;
        map_we       = 1'b0;
        map_waddr    = q_slot;
        map_wdata    = 1'b0;
        fifo_we      = 1'b0;
        fill_next    = fill_reg;
        fresh_next   = fresh_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        done_next    = 1'b0;
        granted_next = '0;
        status_next  = rid_pkg::STATUS_OK;
        case (state_reg)
            rid_pkg::BS_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_idx_reg;
            end
            rid_pkg::BS_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (q_cls.is_free)
                    begin
                        if (!q_cls.in_range)
                        begin
                            done_next   = 1'b1;
                            status_next = rid_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    else if (fill_reg != '0)
                    begin
                        // recycle: slot comes out of the free list next cycle
                        rd_ptr_next = ptr_inc(rd_ptr_reg);
                        fill_next   = fill_reg - CW'(1);
                    end
                    else if (fresh_reg != FULL_CNT)
                    begin
                        map_we       = 1'b1;
                        map_waddr    = fresh_reg[SW-1:0];
                        map_wdata    = 1'b1;
                        fresh_next   = fresh_reg + CW'(1);
                        done_next    = 1'b1;
                        granted_next = id_of(base_id, fresh_reg[SW-1:0]);
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = rid_pkg::STATUS_EXHAUSTED;
                    end
                end
            end
            rid_pkg::BS_READ:
            begin
                done_next = 1'b1;
                if (!hold_free_reg)
                begin
                    map_we       = 1'b1;
                    map_waddr    = fifo_rdata;
                    map_wdata    = 1'b1;
                    granted_next = id_of(base_id, fifo_rdata);
                end
                else if (map_rdata && (fill_reg != FULL_CNT))
                begin
                    map_we      = 1'b1;
                    map_waddr   = hold_slot_reg;
                    fifo_we     = 1'b1;
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                    fill_next   = fill_reg + CW'(1);
                end
                else
                begin
                    status_next = rid_pkg::STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hold_free_reg <= q_cls.is_free;
            hold_slot_reg <= q_slot;
        end
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rid_pkg::BS_CLEAR;
            clr_idx_reg <= '0;
            fill_reg    <= '0;
            fresh_reg   <= '0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rid_pkg::BS_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + SW'(1);
            end
            fill_reg   <= fill_next;
            fresh_reg  <= fresh_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            done_reg   <= done_next;
        end
    end

    assign clearing   = (state_reg == rid_pkg::BS_CLEAR);
    assign done       = done_reg;
    assign granted_id = granted_reg;
    assign status     = status_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("free list count past pool size");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= FULL_CNT)
        else $error("fresh counter past pool size");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != rid_pkg::BS_CLEAR)
        else $error("result issued during clearing pass");

    a_exhausted_real: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == rid_pkg::STATUS_EXHAUSTED)
            |-> (fill_reg == '0 && fresh_reg == FULL_CNT))
        else $error("exhaustion reported with identifiers left");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != rid_pkg::STATUS_OK) |-> granted_reg == '0)
        else $error("nonzero identifier on failed request");

endmodule

### rtl/recycling_id_allocator.sv
// Recycling identifier allocator.
// Request channel: drive cmd (0 allocate, 1 free) and free_id with start high;
// the item is taken at a rising edge where start is high and busy is low.
// Config channel: cfg_data is the base identifier (slot 0), taken when
// cfg_valid and cfg_ready are both high; write it only while the block is idle.
// Results: done is high for exactly one cycle with granted_id and status.
// The receiver cannot stall; every item yields exactly one result, in order.
// Flow: a fresh allocation, an exhausted allocation or an out-of-range free
// reports from the result registers once the back end pops it; a recycled
// allocation or an in-range free also passes through the READ state for the
// registered read of the free list or the in-use map; no item pops in READ.
// A 2-entry queue sits between the front classifier and the back end; busy
// rises when it is full. Reset: base returns to 101, counters and free list
// empty; the in-use map is then cleared one slot per cycle, busy held high.
module recycling_id_allocator #(
    parameter int MAX_IDS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [15:0] free_id,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data,
    output logic        done,
    output logic [15:0] granted_id,
    output logic [1:0]  status
);

    localparam int SW = $clog2(MAX_IDS);

    logic [14:0]         base_reg;
    logic                clearing;
    logic                pop;
    logic                q_valid;
    rid_pkg::req_class_t q_cls;
    logic [SW-1:0]       q_slot;
    rid_pkg::status_t    status_int;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= rid_pkg::BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_reg <= cfg_data;
        end
    end

    rid_front #(.MAX_IDS(MAX_IDS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .free_id  (free_id),
        .base_id  (base_reg),
        .clearing (clearing),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cls    (q_cls),
        .q_slot   (q_slot)
    );

    rid_back #(.MAX_IDS(MAX_IDS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .base_id    (base_reg),
        .q_valid    (q_valid),
        .q_cls      (q_cls),
        .q_slot     (q_slot),
        .pop        (pop),
        .clearing   (clearing),
        .done       (done),
        .granted_id (granted_id),
        .status     (status_int)
    );

    assign status = status_int;

endmodule

### sim/recycling_id_allocator_tb.sv
`timescale 1ns / 100ps

module recycling_id_allocator_tb;

    localparam int MAX_IDS     = 256;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [15:0]      granted;
        rid_pkg::status_t status;
    } grant_t;

    class id_pool_tracker;
        logic [14:0] base;
        int          fresh_used;
        logic [7:0]  freed_slots[MAX_IDS];
        int          rd_ptr;
        int          wr_ptr;
        int          fill;
        bit          held[MAX_IDS];
        grant_t      grants_due[$];
        int          errors;

        function new();
            base       = rid_pkg::BASE_RESET;
            fresh_used = 0;
            rd_ptr     = 0;
            wr_ptr     = 0;
            fill       = 0;
            errors     = 0;
            foreach (held[s])
                held[s] = 1'b0;
        endfunction

        function void set_base(logic [14:0] value);
            base = value;
        endfunction

        function int pending();
            return grants_due.size();
        endfunction

        function int random_held();
            int slots[$];
            for (int s = 0; s < MAX_IDS; s++)
                if (held[s])
                    slots.push_back(s);
            if (slots.size() == 0)
                return -1;
            return slots[$urandom_range(0, slots.size() - 1)];
        endfunction

        function void note_request(logic req_cmd, logic [15:0] req_id);
            grant_t g;
            int     slot;
            int     offset;
            bit     have;
            g.granted = 16'd0;
            g.status  = rid_pkg::STATUS_OK;
            if (req_cmd == rid_pkg::CMD_ALLOC)
            begin
                have = 1'b1;
                if (fill != 0)
                begin
                    // recycle the oldest freed slot first
                    slot   = freed_slots[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % MAX_IDS;
                    fill--;
                end
                else if (fresh_used < MAX_IDS)
                begin
                    slot = fresh_used;
                    fresh_used++;
                end
                else
                begin
                    slot = 0;
                    have = 1'b0;
                end
                if (have)
                begin
                    held[slot] = 1'b1;
                    g.granted  = 16'(int'(base) + slot);
                end
                else
                begin
                    g.status = rid_pkg::STATUS_EXHAUSTED;
                end
            end
            else
            begin
                offset = int'(req_id) - int'(base);
                if (offset < 0 || offset >= MAX_IDS)
                begin
                    g.status = rid_pkg::STATUS_NOT_FOUND;
                end
                else if (!held[offset] || fill >= MAX_IDS)
                begin
                    g.status = rid_pkg::STATUS_NOT_FOUND;
                end
                else
                begin
                    held[offset]        = 1'b0;
                    freed_slots[wr_ptr] = 8'(offset);
                    wr_ptr              = (wr_ptr + 1) % MAX_IDS;
                    fill++;
                end
            end
            grants_due.push_back(g);
        endfunction

        function void check_grant(logic [15:0] got_id, logic [1:0] got_status);
            grant_t g;
            if (grants_due.size() == 0)
            begin
                $error("result with nothing outstanding: granted_id %0d, status %0d",
                       got_id, got_status);
                errors++;
                return;
            end
            g = grants_due.pop_front();
            if (got_id !== g.granted)
            begin
                $error("granted_id: expected %0d, got %0d", g.granted, got_id);
                errors++;
            end
            if (got_status !== g.status)
            begin
                $error("status: expected %0d, got %0d", g.status, got_status);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [15:0] free_id;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [14:0] cfg_data;
    logic        done;
    logic [15:0] granted_id;
    logic [1:0]  status;

    id_pool_tracker pool;
    int             stall_cycles;
    bit             moved;

    recycling_id_allocator #(
        .MAX_IDS(MAX_IDS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .free_id    (free_id),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .granted_id (granted_id),
        .status     (status)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (start && !busy)
            begin
                pool.note_request(cmd, free_id);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                pool.set_base(cfg_data);
                moved = 1'b1;
            end
            if (done)
            begin
                pool.check_grant(granted_id, status);
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("recycling_id_allocator test failed");
                $finish;
            end
        end
    end

    // call at a falling edge; returns at the rising edge that takes the item
    task automatic push_request(input logic req_cmd, input logic [15:0] req_id);
        start   <= 1'b1;
        cmd     <= req_cmd;
        free_id <= req_id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send(input logic req_cmd, input logic [15:0] req_id);
        @(negedge clk);
        push_request(req_cmd, req_id);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pool.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_base(input logic [14:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int alloc_pct);
        int          burst;
        int          pick;
        int          slot;
        int          b;
        logic        req_cmd;
        logic [15:0] req_id;
        burst = $urandom_range(1, 40);
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    wait_drained();
                else if (pick < 8)
                    pause_sender($urandom_range(1, 12));
                burst = $urandom_range(1, 40);
            end
            @(negedge clk);
            b       = int'(pool.base);
            req_cmd = rid_pkg::CMD_FREE;
            req_id  = 16'($urandom);
            if ($urandom_range(0, 99) < alloc_pct)
            begin
                req_cmd = rid_pkg::CMD_ALLOC;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    // release something actually held
                    slot = pool.random_held();
                    if (slot < 0)
                        slot = $urandom_range(0, MAX_IDS - 1);
                    req_id = 16'(b + slot);
                end
                else if (pick >= 85 && pick < 93)
                begin
                    case ($urandom_range(0, 3))
                        0:       req_id = 16'(b - 1);
                        1:       req_id = 16'(b + MAX_IDS);
                        2:       req_id = 16'(b + MAX_IDS - 1);
                        default: req_id = 16'(b);
                    endcase
                end
                else if (pick >= 93)
                begin
                    req_id = 16'(b + $urandom_range(0, MAX_IDS - 1));
                end
            end
            push_request(req_cmd, req_id);
            burst--;
        end
    endtask

    initial
    begin
        pool         = new();
        stall_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = rid_pkg::CMD_ALLOC;
        free_id      = 16'd0;
        cfg_valid    = 1'b0;
        cfg_data     = 15'd0;
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        // default base: fresh grants, recycling, range edges
        send(rid_pkg::CMD_ALLOC, 16'hFFFF);
        send(rid_pkg::CMD_ALLOC, 16'h0000);
        send(rid_pkg::CMD_ALLOC, 16'h5A5A);
        send(rid_pkg::CMD_FREE,  16'd102);
        send(rid_pkg::CMD_FREE,  16'd102);
        send(rid_pkg::CMD_FREE,  16'd100);
        send(rid_pkg::CMD_FREE,  16'd357);
        send(rid_pkg::CMD_FREE,  16'd356);
        send(rid_pkg::CMD_FREE,  16'd0);
        send(rid_pkg::CMD_FREE,  16'hFFFF);
        send(rid_pkg::CMD_ALLOC, 16'd0);
        send(rid_pkg::CMD_FREE,  16'd101);
        send(rid_pkg::CMD_FREE,  16'd103);
        send(rid_pkg::CMD_ALLOC, 16'd0);
        send(rid_pkg::CMD_ALLOC, 16'd0);
        send(rid_pkg::CMD_ALLOC, 16'd0);

        // move the base under held slots, both extremes
        write_base(15'd0);
        send(rid_pkg::CMD_FREE,  16'd0);
        send(rid_pkg::CMD_FREE,  16'd256);
        send(rid_pkg::CMD_ALLOC, 16'd0);
        write_base(15'h7FFF);
        send(rid_pkg::CMD_FREE,  16'd32770);
        send(rid_pkg::CMD_FREE,  16'd32766);
        send(rid_pkg::CMD_FREE,  16'd33023);
        send(rid_pkg::CMD_ALLOC, 16'd0);

        write_base(rid_pkg::BASE_RESET);
        run_phase(300, 55);
        write_base(15'($urandom));
        run_phase(250, 50);
        // allocation-heavy: runs the fresh counter dry
        write_base(15'h7FFF);
        run_phase(400, 95);
        write_base(15'($urandom));
        run_phase(300, 30);
        write_base(15'd0);
        run_phase(250, 50);

        wait_drained();
        repeat (8)
            @(posedge clk);
        if (pool.errors == 0 && pool.pending() == 0)
            $display("recycling_id_allocator test passed");
        else
            $display("recycling_id_allocator test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/rid_pkg.sv
rtl/rid_ram.sv
rtl/rid_front.sv
rtl/rid_back.sv
rtl/recycling_id_allocator.sv
sim/recycling_id_allocator_tb.sv
